// File: sv/bmz_pkg.sv
// Shared constants for the bitmap row horizontal zoom unit.
package bmz_pkg;

   // Fixed field widths.
   localparam int PIXEL_W    = 8;
   localparam int X_FACTOR_W = 5;
   localparam int ROW_BITS_W = 12;
   localparam int POSITION_W = 8;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_X_FACTOR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BITS = 4'd1;

   // Register reset values.
   localparam logic [X_FACTOR_W-1:0] X_FACTOR_RESET = 5'd2;
   localparam logic [ROW_BITS_W-1:0] ROW_BITS_RESET = 12'd8;

   // Default limits for the top level parameters.
   localparam int DEF_MAX_FACTOR   = 16;
   localparam int DEF_MAX_ROW_BITS = 2048;

endpackage

// File: sv/bmz_front.sv
// Front end: accepts source bytes, tracks the row position and sizes each run.
module bmz_front #(
   parameter int MAX_FACTOR   = bmz_pkg::DEF_MAX_FACTOR,
   parameter int MAX_ROW_BITS = bmz_pkg::DEF_MAX_ROW_BITS,
   localparam int FW = $clog2(MAX_FACTOR + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bmz_pkg::PIXEL_W-1:0]    req_pixel_byte,
   input  logic [bmz_pkg::X_FACTOR_W-1:0] x_factor,
   input  logic [bmz_pkg::ROW_BITS_W-1:0] row_bits,
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic [bmz_pkg::PIXEL_W-1:0]    push_pixel,
   output logic [FW-1:0]                  push_factor,
   output logic [FW-1:0]                  push_count,
   output logic                           push_row_end
);

   localparam int RBW = bmz_pkg::ROW_BITS_W;
   localparam int PW  = bmz_pkg::POSITION_W;

   logic [PW-1:0]  position_ff;
   logic [PW-1:0]  position_in;
   logic [FW-1:0]  factor;
   logic [RBW-1:0] row_eff;
   logic [RBW-2:0] row_bytes;
   logic [RBW-2:0] next_index;
   logic [2:0]     partial;
   logic [FW+3:0]  partial_bits;
   logic           at_end;
   logic           accept;

   assign req_stall = !push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      if (x_factor == '0) begin
         factor = FW'(1);
      end else if (int'(x_factor) > MAX_FACTOR) begin
         factor = FW'(MAX_FACTOR);
      end else begin
         factor = FW'(x_factor);
      end

      if (row_bits == '0) begin
         row_eff = RBW'(1);
      end else if (int'(row_bits) > MAX_ROW_BITS) begin
         row_eff = RBW'(MAX_ROW_BITS);
      end else begin
         row_eff = row_bits;
      end
   end

   // Row length in bytes, rounded up.
   assign row_bytes  = (RBW-1)'(({1'b0, row_eff} + (RBW+1)'(7)) >> 3);
   assign next_index = (RBW-1)'(position_ff) + (RBW-1)'(1);
   assign at_end     = next_index >= row_bytes;
   assign partial    = row_eff[2:0];

   // A partial last byte keeps only the output bytes that hold row pixels.
   assign partial_bits = (FW+4)'(partial) * (FW+4)'(factor) + (FW+4)'(7);

   always_comb begin
      if (at_end && partial != 3'd0) begin
         push_count = FW'(partial_bits >> 3);
      end else begin
         push_count = factor;
      end
      position_in = position_ff;
      if (accept) begin
         position_in = at_end ? '0 : position_ff + PW'(1);
      end
   end

   assign push_valid   = req_valid;
   assign push_pixel   = req_pixel_byte;
   assign push_factor  = factor;
   assign push_row_end = at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

endmodule

// File: sv/bmz_queue.sv
// Two-entry queue that decouples the front end from the byte generator.
module bmz_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic             head_valid_ff, head_valid_in;
   logic             tail_valid_ff, tail_valid_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             push;
   logic             pop;

   assign push_ready = !tail_valid_ff;
   assign pop_valid  = head_valid_ff;
   assign pop_data   = head_ff;
   assign push       = push_valid && !tail_valid_ff;
   assign pop        = pop_ready && head_valid_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            // Tail moves up; the tail slot empties, since no push is taken while the tail is full.
            head_in       = tail_ff;
            tail_in       = push_data;
            tail_valid_in = push;
         end else begin
            head_in       = push_data;
            head_valid_in = push;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            tail_in       = push_data;
            tail_valid_in = 1'b1;
         end else begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// File: sv/bmz_back.sv
// Back end: expands one queued source byte into its run of zoomed bytes.
module bmz_back #(
   parameter int MAX_FACTOR = bmz_pkg::DEF_MAX_FACTOR,
   localparam int FW = $clog2(MAX_FACTOR + 1),
   localparam int RW = $clog2(MAX_FACTOR)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  logic [bmz_pkg::PIXEL_W-1:0] pop_pixel,
   input  logic [FW-1:0]               pop_factor,
   input  logic [FW-1:0]               pop_count,
   input  logic                        pop_row_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bmz_pkg::PIXEL_W-1:0] rsp_zoomed_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_row_end
);

   localparam int PXW = bmz_pkg::PIXEL_W;

   logic           busy_ff, busy_in;
   logic [PXW-1:0] pixel_ff, pixel_in;
   logic [FW-1:0]  factor_ff, factor_in;
   logic [FW-1:0]  left_ff, left_in;
   logic           row_end_ff, row_end_in;
   logic [2:0]     src_bit_ff, src_bit_in;
   logic [RW-1:0]  rep_ff, rep_in;

   logic           out_valid_ff, out_valid_in;
   logic [PXW-1:0] out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;
   logic           out_row_end_ff, out_row_end_in;

   logic           out_free;
   logic           issue;
   logic           last;
   logic           take;
   logic [PXW-1:0] zoomed;
   logic [2:0]     src_bit_next;
   logic [RW-1:0]  rep_next;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign issue     = busy_ff && out_free;
   assign last      = left_ff == FW'(1);
   assign take      = pop_valid && (!busy_ff || (issue && last));
   assign pop_ready = take;

   // Walk eight magnified bits, most significant first. The walker holds the
   // current source bit and how many more repeats of it remain.
   always_comb begin
      logic [2:0]    sb;
      logic [RW-1:0] r;
      logic [RW-1:0] f_m1;
      sb   = src_bit_ff;
      r    = rep_ff;
      f_m1 = RW'(factor_ff - FW'(1));
      for (int k = PXW - 1; k >= 0; k--) begin
         zoomed[k] = pixel_ff[sb];
         if (r == '0) begin
            sb = sb - 3'd1;
            r  = f_m1;
         end else begin
            r = r - RW'(1);
         end
      end
      src_bit_next = sb;
      rep_next     = r;
   end

   always_comb begin
      busy_in    = busy_ff;
      pixel_in   = pixel_ff;
      factor_in  = factor_ff;
      left_in    = left_ff;
      row_end_in = row_end_ff;
      src_bit_in = src_bit_ff;
      rep_in     = rep_ff;
      if (take) begin
         busy_in    = 1'b1;
         pixel_in   = pop_pixel;
         factor_in  = pop_factor;
         left_in    = pop_count;
         row_end_in = pop_row_end;
         src_bit_in = 3'd7;
         rep_in     = RW'(pop_factor - FW'(1));
      end else if (issue) begin
         left_in    = left_ff - FW'(1);
         src_bit_in = src_bit_next;
         rep_in     = rep_next;
         if (last) begin
            busy_in = 1'b0;
         end
      end

      out_valid_in   = out_valid_ff;
      out_byte_in    = out_byte_ff;
      out_last_in    = out_last_ff;
      out_row_end_in = out_row_end_ff;
      if (out_free) begin
         out_valid_in = issue;
         if (issue) begin
            out_byte_in    = zoomed;
            out_last_in    = last;
            out_row_end_in = row_end_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      pixel_ff       <= pixel_in;
      factor_ff      <= factor_in;
      left_ff        <= left_in;
      row_end_ff     <= row_end_in;
      src_bit_ff     <= src_bit_in;
      rep_ff         <= rep_in;
      out_byte_ff    <= out_byte_in;
      out_last_ff    <= out_last_in;
      out_row_end_ff <= out_row_end_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_zoomed_byte = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_row_end     = out_row_end_ff;

endmodule

// File: sv/bitmap_row_horizontal_zoom_unit.sv
// Top level of the bitmap row horizontal zoom unit.
// The first zoomed byte of an item passes through the queue, the byte generator's run registers
// and the output register before it is shown. The byte generator gives one zoomed byte per
// cycle while rsp_stall is low; an item has x_factor results for a full byte, up to 16 at the default limit.
// Reset clears the row position, the queue and the output register, and sets x_factor
// to 2 and row_bits to 8.
module bitmap_row_horizontal_zoom_unit #(
   parameter int MAX_FACTOR   = bmz_pkg::DEF_MAX_FACTOR,
   parameter int MAX_ROW_BITS = bmz_pkg::DEF_MAX_ROW_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Source bytes.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bmz_pkg::PIXEL_W-1:0]      req_pixel_byte,
   // Zoomed bytes.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bmz_pkg::PIXEL_W-1:0]      rsp_zoomed_byte,
   output logic                             rsp_last_of_run,
   output logic                             rsp_row_end,
   // Configuration writes.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bmz_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bmz_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int FW  = $clog2(MAX_FACTOR + 1);
   localparam int QW  = bmz_pkg::PIXEL_W + 2 * FW + 1;
   localparam int XW  = bmz_pkg::X_FACTOR_W;
   localparam int RBW = bmz_pkg::ROW_BITS_W;

   // Configuration registers. Writes to an unknown index are dropped.
   logic [XW-1:0]  x_factor_ff, x_factor_in;
   logic [RBW-1:0] row_bits_ff, row_bits_in;

   // Front end to queue.
   logic                        push_valid;
   logic                        push_ready;
   logic [bmz_pkg::PIXEL_W-1:0] push_pixel;
   logic [FW-1:0]               push_factor;
   logic [FW-1:0]               push_count;
   logic                        push_row_end;

   // Queue to back end.
   logic                        pop_valid;
   logic                        pop_ready;
   logic [QW-1:0]               pop_data;
   logic [bmz_pkg::PIXEL_W-1:0] pop_pixel;
   logic [FW-1:0]               pop_factor;
   logic [FW-1:0]               pop_count;
   logic                        pop_row_end;

   // The register file never holds off a write.
   assign csr_ready = 1'b1;

   always_comb begin
      x_factor_in = x_factor_ff;
      row_bits_in = row_bits_ff;
      if (csr_valid) begin
         if (csr_index == bmz_pkg::CSR_X_FACTOR) begin
            x_factor_in = csr_data[XW-1:0];
         end else if (csr_index == bmz_pkg::CSR_ROW_BITS) begin
            row_bits_in = csr_data[RBW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_factor_ff <= bmz_pkg::X_FACTOR_RESET;
         row_bits_ff <= bmz_pkg::ROW_BITS_RESET;
      end else begin
         x_factor_ff <= x_factor_in;
         row_bits_ff <= row_bits_in;
      end
   end

   // The front end clamps the registers, works out whether this byte ends
   // the row and how many output bytes it produces, and advances the row
   // position. It finishes each item in the cycle it is accepted.
   bmz_front #(
      .MAX_FACTOR   (MAX_FACTOR),
      .MAX_ROW_BITS (MAX_ROW_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_byte (req_pixel_byte),
      .x_factor       (x_factor_ff),
      .row_bits       (row_bits_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_pixel     (push_pixel),
      .push_factor    (push_factor),
      .push_count     (push_count),
      .push_row_end   (push_row_end)
   );

   // Sized runs wait here, so the front end keeps taking source bytes while
   // the back end is still emitting an earlier run.
   bmz_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_pixel, push_factor, push_count, push_row_end}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_pixel, pop_factor, pop_count, pop_row_end} = pop_data;

   // The back end produces one zoomed byte per cycle while rsp_stall does not hold
   // its output register, and loads the next run in the same cycle as the last byte
   // of the current one.
   bmz_back #(
      .MAX_FACTOR (MAX_FACTOR)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_pixel       (pop_pixel),
      .pop_factor      (pop_factor),
      .pop_count       (pop_count),
      .pop_row_end     (pop_row_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_zoomed_byte (rsp_zoomed_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_row_end     (rsp_row_end)
   );

endmodule
